[rtl/core/ddemc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddemc_pkg
// Shared types and constants for the two-wheel drive move controller.
// ----------------------------------------------------------------------------
package ddemc_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int NUM_W       = 64;
    localparam int DEN_W       = 48;
    localparam int PROD_W      = 76;
    localparam int QCNT_W      = $clog2(NUM_W);
    localparam int FIFO_DEPTH  = 2;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam logic [17:0] PI_Q16 = 18'd205887;

    localparam logic [2:0] ACT_TICK    = 3'd0;
    localparam logic [2:0] ACT_LEFT    = 3'd1;
    localparam logic [2:0] ACT_RIGHT   = 3'd2;
    localparam logic [2:0] ACT_SET_DIR = 3'd3;
    localparam logic [2:0] ACT_SET_SPD = 3'd4;
    localparam logic [2:0] ACT_FWD     = 3'd5;
    localparam logic [2:0] ACT_BACK    = 3'd6;
    localparam logic [2:0] ACT_TURN    = 3'd7;

    localparam logic [2:0] CFG_SPEED   = 3'd0;
    localparam logic [2:0] CFG_PERIOD  = 3'd1;
    localparam logic [2:0] CFG_DIAM    = 3'd2;
    localparam logic [2:0] CFG_SLOTS   = 3'd3;
    localparam logic [2:0] CFG_SPACING = 3'd4;
    localparam logic [2:0] CFG_REP_EN  = 3'd5;
    localparam logic [2:0] CFG_BEEP_EN = 3'd6;

    localparam logic [1:0] SIDE_LEFT  = 2'd0;
    localparam logic [1:0] SIDE_RIGHT = 2'd1;
    localparam logic [1:0] SIDE_NONE  = 2'd3;

    localparam logic [1:0] MOVE_IDLE = 2'd0;
    localparam logic [1:0] MOVE_TURN = 2'd1;
    localparam logic [1:0] MOVE_FWD  = 2'd2;
    localparam logic [1:0] MOVE_BACK = 2'd3;

    typedef enum logic [1:0] {
        K_TICK,
        K_IMPULSE,
        K_SET,
        K_MOVE
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [2:0]        action;
        logic [1:0]        side;
        logic signed [1:0] dir;
        logic [7:0]        speed;
        logic [15:0]       amount;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    typedef struct packed {
        logic [7:0]  default_speed;
        logic [15:0] report_period_ms;
        logic [15:0] wheel_diameter;
        logic [7:0]  slot_count;
        logic [15:0] wheel_spacing;
        logic        report_enable;
        logic        beep_enable;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TGT1,
        ST_TGT2,
        ST_TGT3,
        ST_RPT1,
        ST_RPT2,
        ST_RPT3,
        ST_RPT4,
        ST_DSTART,
        ST_DIV,
        ST_EMIT
    } t_state;

endpackage

[rtl/core/ddemc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddemc_front
// Accepts input words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module ddemc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [2:0]           i_action,
    input  logic [1:0]           i_side,
    input  logic signed [1:0]    i_direction,
    input  logic [7:0]           i_speed,
    input  logic signed [15:0]   i_amount,
    output ddemc_pkg::t_head     o_head,
    input  logic                 i_pop
);
    import ddemc_pkg::*;

    t_item             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]    r_count;
    t_item             w_item;
    logic              w_push;
    logic              w_pop;

    always_comb begin
        w_item.action = i_action;
        w_item.side   = i_side;
        w_item.speed  = i_speed;
        w_item.amount = i_amount;
        case (i_direction)
            2'sd1:   w_item.dir = 2'sd1;
            -2'sd1:  w_item.dir = -2'sd1;
            default: w_item.dir = 2'sd0;
        endcase
        case (i_action)
            ACT_TICK:                w_item.kind = K_TICK;
            ACT_LEFT, ACT_RIGHT:     w_item.kind = K_IMPULSE;
            ACT_SET_DIR, ACT_SET_SPD: w_item.kind = K_SET;
            default:                 w_item.kind = K_MOVE;
        endcase
    end

    assign o_stall = (r_count == (PTR_W+1)'(FIFO_DEPTH));
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (PTR_W+1)'(w_push) - (PTR_W+1)'(w_pop);
        end
    end

endmodule

[rtl/core/ddemc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddemc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddemc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ddemc_pkg::NUM_W-1:0]   i_num,
    input  logic [ddemc_pkg::DEN_W-1:0]   i_den,
    output logic                          o_done,
    output logic [ddemc_pkg::NUM_W-1:0]   o_quo
);
    import ddemc_pkg::*;

    logic                r_busy;
    logic [QCNT_W-1:0]   r_cnt;
    logic [NUM_W-1:0]    r_quo;
    logic [DEN_W-1:0]    r_den;
    logic [DEN_W:0]      r_rem;
    logic                r_done;
    logic [DEN_W+1:0]    w_shift;
    logic                w_ge;

    assign w_shift = {r_rem, r_quo[NUM_W-1]};
    assign w_ge    = (w_shift >= {2'b00, r_den});
    assign o_done  = r_done;
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == QCNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= (DEN_W+1)'(w_shift - {2'b00, r_den});
            end else begin
                r_rem <= w_shift[DEN_W:0];
            end
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

endmodule

[rtl/core/ddemc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddemc_back
// Executes queued words: wheel state, impulse counts, move targets, reports.
// ----------------------------------------------------------------------------
module ddemc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ddemc_pkg::t_cfg      i_cfg,
    input  ddemc_pkg::t_head     i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_left_fwd,
    output logic                 o_left_rev,
    output logic                 o_right_fwd,
    output logic                 o_right_rev,
    output logic [7:0]           o_left_pwm,
    output logic [7:0]           o_right_pwm,
    output logic [1:0]           o_mode,
    output logic [2:0]           o_beep_level,
    output logic signed [15:0]   o_remaining_cm,
    output logic                 o_move_done
);
    import ddemc_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    t_state                    r_state, n_state;
    t_item                     r_cmd, n_cmd;
    logic signed [1:0]         r_ldir, n_ldir, r_rdir, n_rdir;
    logic [7:0]                r_lduty, n_lduty, r_rduty, n_rduty;
    logic [COUNT_WIDTH-1:0]    r_lcnt, n_lcnt, r_rcnt, n_rcnt, r_target, n_target;
    logic [1:0]                r_kind, n_kind;
    logic [15:0]               r_cm, n_cm;
    logic [15:0]               r_ms, n_ms;
    logic                      r_first, n_first;
    logic [15:0]               r_arg, n_arg;
    logic                      r_turn, n_turn;
    logic                      r_for_tgt, n_for_tgt;
    logic [PROD_W-1:0]         r_prod, n_prod;
    logic [NUM_W-1:0]          r_num, n_num;
    logic [DEN_W-1:0]          r_den, n_den;
    logic [15:0]               r_rem, n_rem;
    logic                      r_done, n_done;
    logic                      r_out_valid;

    logic                      w_busy, w_out_free, w_start, w_div_done;
    logic [NUM_W-1:0]          w_quo;
    logic [COUNT_WIDTH-1:0]    w_lcnt_inc, w_rcnt_inc, w_min_new, w_min, w_clamp;
    logic [15:0]               w_ms_inc, w_deg;
    logic                      w_tick_rpt, w_tick_upd, w_imp_fin, w_set_ok, w_move_ok;
    logic [COUNT_WIDTH-1:0]    w_tgt_sat;
    logic signed [9:0]         w_vl, w_vr;
    logic signed [10:0]        w_vsum;
    logic [8:0]                w_beep_x;

    assign w_busy     = (r_kind != MOVE_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_pop      = (r_state == ST_IDLE) && i_head.valid && w_out_free;
    assign w_start    = (r_state == ST_DSTART);

    ddemc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        w_lcnt_inc = (r_lcnt != CNT_MAX) ? r_lcnt + 1'b1 : r_lcnt;
        w_rcnt_inc = (r_rcnt != CNT_MAX) ? r_rcnt + 1'b1 : r_rcnt;
        if (r_cmd.action == ACT_LEFT) begin
            w_min_new = (w_lcnt_inc < r_rcnt) ? w_lcnt_inc : r_rcnt;
        end else begin
            w_min_new = (r_lcnt < w_rcnt_inc) ? r_lcnt : w_rcnt_inc;
        end
        w_min   = (r_lcnt < r_rcnt) ? r_lcnt : r_rcnt;
        w_clamp = (w_min > r_target) ? r_target : w_min;
        w_ms_inc = (r_ms != 16'hFFFF) ? r_ms + 1'b1 : r_ms;
        w_deg = r_cmd.amount[15] ? 16'(-r_cmd.amount) : r_cmd.amount;
        w_tgt_sat = (w_quo[NUM_W-1:COUNT_WIDTH] != '0) ? CNT_MAX
                                                       : w_quo[COUNT_WIDTH-1:0];

        w_tick_rpt = 1'b0;
        w_tick_upd = 1'b0;
        if (r_kind == MOVE_FWD || r_kind == MOVE_BACK) begin
            w_tick_upd = 1'b1;
            w_tick_rpt = r_first || (w_ms_inc >= i_cfg.report_period_ms);
        end
        w_imp_fin = w_busy && (w_min_new >= r_target);
        w_set_ok  = !w_busy && (r_cmd.side != SIDE_NONE);
        w_move_ok = !w_busy && (i_cfg.default_speed != '0) && (i_cfg.slot_count != '0)
                    && (i_cfg.wheel_diameter != '0);
        if (r_cmd.action == ACT_TURN) begin
            w_move_ok = w_move_ok && (r_cmd.amount != '0) && (i_cfg.wheel_spacing != '0);
        end else begin
            w_move_ok = w_move_ok && !r_cmd.amount[15] && (r_cmd.amount != '0)
                        && i_cfg.report_enable && (i_cfg.report_period_ms != '0);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_IDLE;
                case (r_cmd.kind)
                    K_TICK: begin
                        if (w_tick_rpt) begin
                            n_state = (i_cfg.slot_count == '0) ? ST_EMIT : ST_RPT1;
                        end
                    end
                    K_IMPULSE: begin
                        if (w_imp_fin) begin
                            n_state = ST_EMIT;
                        end
                    end
                    K_SET: begin
                        if (w_set_ok) begin
                            n_state = ST_EMIT;
                        end
                    end
                    default: begin
                        if (w_move_ok) begin
                            n_state = ST_TGT1;
                        end
                    end
                endcase
            end
            ST_TGT1:   n_state = ST_TGT2;
            ST_TGT2:   n_state = ST_TGT3;
            ST_TGT3:   n_state = ST_DSTART;
            ST_RPT1:   n_state = ST_RPT2;
            ST_RPT2:   n_state = ST_RPT3;
            ST_RPT3:   n_state = ST_RPT4;
            ST_RPT4:   n_state = (r_prod[NUM_W-1:0] >= r_num) ? ST_EMIT : ST_DSTART;
            ST_DSTART: n_state = ST_DIV;
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_cmd     = r_cmd;
        n_ldir    = r_ldir;
        n_rdir    = r_rdir;
        n_lduty   = r_lduty;
        n_rduty   = r_rduty;
        n_lcnt    = r_lcnt;
        n_rcnt    = r_rcnt;
        n_target  = r_target;
        n_kind    = r_kind;
        n_cm      = r_cm;
        n_ms      = r_ms;
        n_first   = r_first;
        n_arg     = r_arg;
        n_turn    = r_turn;
        n_for_tgt = r_for_tgt;
        n_prod    = r_prod;
        n_num     = r_num;
        n_den     = r_den;
        n_rem     = r_rem;
        n_done    = r_done;
        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    n_cmd = i_head.item;
                end
            end
            ST_DECODE: begin
                n_done = 1'b0;
                n_rem  = 16'hFFFF;
                case (r_cmd.kind)
                    K_TICK: begin
                        if (w_tick_upd) begin
                            if (w_tick_rpt) begin
                                n_first = 1'b0;
                                n_ms    = '0;
                                n_rem   = r_cm;
                            end else begin
                                n_ms = w_ms_inc;
                            end
                        end
                    end
                    K_IMPULSE: begin
                        if (r_cmd.action == ACT_LEFT) begin
                            n_lcnt = w_lcnt_inc;
                        end else begin
                            n_rcnt = w_rcnt_inc;
                        end
                        if (w_imp_fin) begin
                            n_rem   = (r_kind == MOVE_TURN) ? 16'hFFFF : 16'h0000;
                            n_done  = 1'b1;
                            n_ldir  = '0;
                            n_rdir  = '0;
                            n_kind  = MOVE_IDLE;
                            n_first = 1'b1;
                        end
                    end
                    K_SET: begin
                        if (w_set_ok) begin
                            if (r_cmd.side != SIDE_RIGHT) begin
                                if (r_cmd.action == ACT_SET_DIR) begin
                                    n_ldir = r_cmd.dir;
                                end else begin
                                    n_lduty = r_cmd.speed;
                                end
                            end
                            if (r_cmd.side != SIDE_LEFT) begin
                                if (r_cmd.action == ACT_SET_DIR) begin
                                    n_rdir = r_cmd.dir;
                                end else begin
                                    n_rduty = r_cmd.speed;
                                end
                            end
                        end
                    end
                    default: begin
                        if (w_move_ok) begin
                            n_turn    = (r_cmd.action == ACT_TURN);
                            n_for_tgt = 1'b1;
                            n_lcnt    = '0;
                            n_rcnt    = '0;
                            n_lduty   = i_cfg.default_speed;
                            n_rduty   = i_cfg.default_speed;
                            n_ms      = '0;
                            n_first   = 1'b1;
                            if (r_cmd.action == ACT_TURN) begin
                                n_arg  = w_deg;
                                n_ldir = r_cmd.amount[15] ? -2'sd1 : 2'sd1;
                                n_rdir = r_cmd.amount[15] ? 2'sd1 : -2'sd1;
                                n_kind = MOVE_TURN;
                                n_cm   = '0;
                            end else begin
                                n_arg  = r_cmd.amount;
                                n_ldir = (r_cmd.action == ACT_FWD) ? 2'sd1 : -2'sd1;
                                n_rdir = (r_cmd.action == ACT_FWD) ? 2'sd1 : -2'sd1;
                                n_kind = (r_cmd.action == ACT_FWD) ? MOVE_FWD : MOVE_BACK;
                                n_cm   = r_cmd.amount;
                            end
                        end
                    end
                endcase
            end
            ST_TGT1: begin
                if (r_turn) begin
                    n_prod = PROD_W'(i_cfg.wheel_spacing * r_arg);
                end else begin
                    n_prod = PROD_W'(r_arg * i_cfg.slot_count);
                end
            end
            ST_TGT2: begin
                if (r_turn) begin
                    n_num = NUM_W'(r_prod[31:0] * i_cfg.slot_count);
                    n_den = DEN_W'(i_cfg.wheel_diameter * 9'd360);
                end else begin
                    n_num = NUM_W'({r_prod[23:0], 24'h0});
                    n_den = DEN_W'(PI_Q16 * i_cfg.wheel_diameter);
                end
            end
            ST_TGT3: begin
                n_num = {r_num[NUM_W-2:0], 1'b0} + NUM_W'(r_den);
                n_den = {r_den[DEN_W-2:0], 1'b0};
            end
            ST_RPT1: begin
                n_for_tgt = 1'b0;
                n_prod    = PROD_W'(w_clamp * PI_Q16);
            end
            ST_RPT2: begin
                n_prod = PROD_W'(r_prod[COUNT_WIDTH+17:0] * i_cfg.wheel_diameter);
            end
            ST_RPT3: begin
                n_prod = PROD_W'(r_prod[COUNT_WIDTH+33:0] * 10'd1000);
                n_num  = NUM_W'({33'((25'(r_cm) * 25'd1000 + 25'd999) * i_cfg.slot_count),
                                 24'h0});
            end
            ST_RPT4: begin
                if (r_prod[NUM_W-1:0] >= r_num) begin
                    n_rem = '0;
                end else begin
                    n_num = r_num - r_prod[NUM_W-1:0];
                    n_den = DEN_W'({18'(i_cfg.slot_count * 10'd1000), 24'h0});
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    if (r_for_tgt) begin
                        n_target = w_tgt_sat;
                        if (w_tgt_sat == '0) begin
                            n_rem   = (r_kind == MOVE_TURN) ? 16'hFFFF : 16'h0000;
                            n_done  = 1'b1;
                            n_ldir  = '0;
                            n_rdir  = '0;
                            n_kind  = MOVE_IDLE;
                            n_first = 1'b1;
                        end
                    end else begin
                        n_rem = w_quo[15:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_arg     <= n_arg;
        r_turn    <= n_turn;
        r_for_tgt <= n_for_tgt;
        r_prod    <= n_prod;
        r_num     <= n_num;
        r_den     <= n_den;
        r_rem     <= n_rem;
        r_done    <= n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ldir   <= '0;
            r_rdir   <= '0;
            r_lduty  <= '0;
            r_rduty  <= '0;
            r_lcnt   <= '0;
            r_rcnt   <= '0;
            r_target <= '0;
            r_kind   <= MOVE_IDLE;
            r_cm     <= '0;
            r_ms     <= '0;
            r_first  <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_ldir   <= n_ldir;
            r_rdir   <= n_rdir;
            r_lduty  <= n_lduty;
            r_rduty  <= n_rduty;
            r_lcnt   <= n_lcnt;
            r_rcnt   <= n_rcnt;
            r_target <= n_target;
            r_kind   <= n_kind;
            r_cm     <= n_cm;
            r_ms     <= n_ms;
            r_first  <= n_first;
        end
    end

    // result word
    always_comb begin
        w_vl     = r_ldir * $signed({2'b00, r_lduty});
        w_vr     = r_rdir * $signed({2'b00, r_rduty});
        w_vsum   = 11'(w_vl) + 11'(w_vr);
        w_beep_x = 9'((10'(r_lduty) + 10'(r_rduty)) >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT) begin
            o_left_fwd     <= (r_ldir == 2'sd1);
            o_left_rev     <= (r_ldir == -2'sd1);
            o_right_fwd    <= (r_rdir == 2'sd1);
            o_right_rev    <= (r_rdir == -2'sd1);
            o_left_pwm     <= r_lduty;
            o_right_pwm    <= r_rduty;
            o_remaining_cm <= r_rem;
            o_move_done    <= r_done;
            if (w_vl == '0 && w_vr == '0) begin
                o_mode <= MOVE_IDLE;
            end else if (w_vl != w_vr) begin
                o_mode <= MOVE_TURN;
            end else if (w_vl > 0) begin
                o_mode <= MOVE_FWD;
            end else begin
                o_mode <= MOVE_BACK;
            end
            if (!i_cfg.beep_enable || w_vsum >= 0) begin
                o_beep_level <= 3'd0;
            end else if (w_beep_x >= 9'd226) begin
                o_beep_level <= 3'd4;
            end else if (w_beep_x >= 9'd151) begin
                o_beep_level <= 3'd3;
            end else if (w_beep_x >= 9'd76) begin
                o_beep_level <= 3'd2;
            end else if (w_beep_x >= 9'd1) begin
                o_beep_level <= 3'd1;
            end else begin
                o_beep_level <= 3'd0;
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule

[rtl/core/diff_drive_encoder_move_control.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_encoder_move_control
// Two-wheel drive controller with encoder-counted distance and turn moves.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall) carries one command word: tick, left or
// right impulse, set direction, set speed, go forward, go back or turn.
// Output channel (o_valid / i_stall) carries the bridge levels, PWM duties,
// motion mode, beep level, remaining distance and move-done flag.
// A two-word queue sits after the input; the back end drains it one word
// at a time. Impulses and set commands pass from the queue head through
// the IDLE, DECODE and EMIT states to the output register. A move runs a
// 3-stage multiply and a radix-2 divide for its target; a distance report
// runs a 4-stage multiply chain and, unless nothing is left, the same divider.
// The divider sets the rate of moves and reports.
// Reset clears wheel state, counts and queue; configuration registers go
// to zero. While i_stall holds a result, the queue keeps taking words
// until it fills; the back end waits until the result is taken.
// ----------------------------------------------------------------------------
module diff_drive_encoder_move_control (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [2:0]           i_action,
    input  logic [1:0]           i_side,
    input  logic signed [1:0]    i_direction,
    input  logic [7:0]           i_speed,
    input  logic signed [15:0]   i_amount,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_left_fwd,
    output logic                 o_left_rev,
    output logic                 o_right_fwd,
    output logic                 o_right_rev,
    output logic [7:0]           o_left_pwm,
    output logic [7:0]           o_right_pwm,
    output logic [1:0]           o_mode,
    output logic [2:0]           o_beep_level,
    output logic signed [15:0]   o_remaining_cm,
    output logic                 o_move_done
);
    import ddemc_pkg::*;

    t_cfg  r_cfg;
    t_head w_head;
    logic  w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SPEED:   r_cfg.default_speed    <= i_cfg_data[7:0];
                CFG_PERIOD:  r_cfg.report_period_ms <= i_cfg_data;
                CFG_DIAM:    r_cfg.wheel_diameter   <= i_cfg_data;
                CFG_SLOTS:   r_cfg.slot_count       <= i_cfg_data[7:0];
                CFG_SPACING: r_cfg.wheel_spacing    <= i_cfg_data;
                CFG_REP_EN:  r_cfg.report_enable    <= i_cfg_data[0];
                CFG_BEEP_EN: r_cfg.beep_enable      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    ddemc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_side      (i_side),
        .i_direction (i_direction),
        .i_speed     (i_speed),
        .i_amount    (i_amount),
        .o_head      (w_head),
        .i_pop       (w_pop)
    );

    ddemc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_left_fwd     (o_left_fwd),
        .o_left_rev     (o_left_rev),
        .o_right_fwd    (o_right_fwd),
        .o_right_rev    (o_right_rev),
        .o_left_pwm     (o_left_pwm),
        .o_right_pwm    (o_right_pwm),
        .o_mode         (o_mode),
        .o_beep_level   (o_beep_level),
        .o_remaining_cm (o_remaining_cm),
        .o_move_done    (o_move_done)
    );

endmodule

[verif/diff_drive_encoder_move_control_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_encoder_move_control_tb
// Self-checking bench for the two-wheel drive move controller.
// ----------------------------------------------------------------------------
// A directed table of command words runs first, then phases of random words
// under different register settings: manual commands, distance and turn moves
// followed by impulses and ticks until they end, and random noise. Every
// accepted word goes through a behavioral model of the controller; results
// are compared in order against the expected words it produces. Both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module diff_drive_encoder_move_control_tb;
    import ddemc_pkg::*;

    localparam int          WATCHDOG   = 6000;
    localparam logic [1:0]  DIR_STOP   = 2'b00;
    localparam logic [1:0]  DIR_FWD    = 2'b01;
    localparam logic [1:0]  DIR_ILLEGAL = 2'b10;
    localparam logic [1:0]  DIR_REV    = 2'b11;
    localparam logic [1:0]  SIDE_BOTH  = 2'd2;
    localparam longint unsigned COUNT_TOP = (64'd1 << COUNT_WIDTH) - 64'd1;

    typedef struct packed {
        logic              lf;
        logic              lr;
        logic              rf;
        logic              rr;
        logic [7:0]        lpwm;
        logic [7:0]        rpwm;
        logic [1:0]        mode;
        logic [2:0]        beep;
        logic signed [15:0] rem;
        logic              done;
    } t_motion;

    typedef struct packed {
        logic [2:0]  action;
        logic [1:0]  side;
        logic [1:0]  dir;
        logic [7:0]  speed;
        logic [15:0] amount;
        logic        typed;
        t_motion     exp;
    } t_row;

    logic i_clk, i_rst_n;
    logic i_cfg_wr_en;
    logic [2:0] i_cfg_index;
    logic [15:0] i_cfg_data;
    logic i_valid, o_stall;
    logic [2:0] i_action;
    logic [1:0] i_side;
    logic signed [1:0] i_direction;
    logic [7:0] i_speed;
    logic signed [15:0] i_amount;
    logic o_valid, i_stall;
    logic o_left_fwd, o_left_rev, o_right_fwd, o_right_rev;
    logic [7:0] o_left_pwm, o_right_pwm;
    logic [1:0] o_mode;
    logic [2:0] o_beep_level;
    logic signed [15:0] o_remaining_cm;
    logic o_move_done;

    diff_drive_encoder_move_control uut (.*);

    // controller model state
    longint unsigned c_speed, c_period, c_diam, c_slots, c_spacing, c_rep_en, c_beep_en;
    int              l_dir, r_dir;
    int unsigned     l_duty, r_duty, kind, cm, ms_count;
    longint unsigned l_cnt, r_cnt, target;
    bit              first_due;

    t_motion motion_q[$];
    int      word_cnt;
    int      idle_cycles;
    bit      failed;
    bit      row_typed;
    t_motion row_exp;
    bit      quiet;
    int      stall_left;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int dir_of(logic [1:0] raw);
        if (raw == DIR_FWD) return 1;
        if (raw == DIR_REV) return -1;
        return 0;
    endfunction

    function automatic longint unsigned round_q(longint unsigned n, longint unsigned d);
        longint unsigned q;
        q = (2 * n + d) / (2 * d);
        return (q > COUNT_TOP) ? COUNT_TOP : q;
    endfunction

    function automatic longint unsigned move_target(logic [2:0] act, logic [15:0] amt);
        longint signed a;
        a = $signed(amt);
        if (act == ACT_TURN) begin
            if (a < 0) a = -a;
            return round_q(c_spacing * a * c_slots, 360 * c_diam);
        end
        return round_q((a * c_slots) << 24, longint'(PI_Q16) * c_diam);
    endfunction

    function automatic t_motion motion(int rem, bit done);
        t_motion m;
        int vl, vr;
        vl = l_dir * int'(l_duty);
        vr = r_dir * int'(r_duty);
        m.lf   = (l_dir == 1);
        m.lr   = (l_dir == -1);
        m.rf   = (r_dir == 1);
        m.rr   = (r_dir == -1);
        m.lpwm = l_duty[7:0];
        m.rpwm = r_duty[7:0];
        if (vl == 0 && vr == 0) m.mode = MOVE_IDLE;
        else if (vl != vr) m.mode = MOVE_TURN;
        else if (vl > 0) m.mode = MOVE_FWD;
        else m.mode = MOVE_BACK;
        m.beep = 3'd0;
        if (c_beep_en != 0 && vl + vr < 0)
            m.beep = (((l_duty + r_duty) / 2 + 74) / 75 > 4) ? 3'd4
                : 3'(((l_duty + r_duty) / 2 + 74) / 75);
        m.rem  = 16'(rem);
        m.done = done;
        return m;
    endfunction

    function automatic int distance_left();
        longint unsigned m, unit, a, b;
        m = (l_cnt < r_cnt) ? l_cnt : r_cnt;
        if (c_slots == 0) return int'(cm);
        if (m > target) m = target;
        unit = c_slots << 24;
        a = unit * (longint'(cm) * 1000 + 999);
        b = m * longint'(PI_Q16) * c_diam * 1000;
        if (b >= a) return 0;
        return int'((a - b) / (unit * 1000));
    endfunction

    function automatic t_motion end_move();
        int rem;
        rem = (kind == MOVE_TURN) ? -1 : 0;
        l_dir = 0;
        r_dir = 0;
        kind = MOVE_IDLE;
        first_due = 1'b1;
        return motion(rem, 1'b1);
    endfunction

    // returns 1 when the word produces a result
    function automatic bit drive_step(logic [2:0] act, logic [1:0] side, logic [1:0] dir,
                                      logic [7:0] spd, logic [15:0] amt, output t_motion res);
        bit busy;
        longint signed a;
        busy = (kind != MOVE_IDLE);
        a = $signed(amt);
        case (act)
            ACT_TICK: begin
                if (kind < MOVE_FWD) return 0;
                if (first_due) first_due = 1'b0;
                else begin
                    if (ms_count < 16'hFFFF) ms_count++;
                    if (ms_count < c_period) return 0;
                end
                ms_count = 0;
                res = motion(distance_left(), 1'b0);
                return 1;
            end
            ACT_LEFT, ACT_RIGHT: begin
                if (act == ACT_LEFT) begin
                    if (l_cnt < COUNT_TOP) l_cnt++;
                end else if (r_cnt < COUNT_TOP) r_cnt++;
                if (busy && ((l_cnt < r_cnt) ? l_cnt : r_cnt) >= target) begin
                    res = end_move();
                    return 1;
                end
                return 0;
            end
            ACT_SET_DIR, ACT_SET_SPD: begin
                if (busy || side == SIDE_NONE) return 0;
                if (side != SIDE_RIGHT) begin
                    if (act == ACT_SET_DIR) l_dir = dir_of(dir); else l_duty = spd;
                end
                if (side != SIDE_LEFT) begin
                    if (act == ACT_SET_DIR) r_dir = dir_of(dir); else r_duty = spd;
                end
                res = motion(-1, 1'b0);
                return 1;
            end
            default: ;
        endcase
        if (busy || c_speed == 0 || c_slots == 0 || c_diam == 0) return 0;
        if (act == ACT_TURN) begin
            if (a == 0 || c_spacing == 0) return 0;
            target = move_target(act, amt);
            l_dir = (a > 0) ? 1 : -1;
            r_dir = -l_dir;
            kind = MOVE_TURN;
            cm = 0;
        end else begin
            if (a <= 0 || c_rep_en == 0 || c_period == 0) return 0;
            target = move_target(act, amt);
            l_dir = (act == ACT_FWD) ? 1 : -1;
            r_dir = l_dir;
            kind = (act == ACT_FWD) ? MOVE_FWD : MOVE_BACK;
            cm = int'(a);
        end
        l_cnt = 0;
        r_cnt = 0;
        l_duty = c_speed;
        r_duty = c_speed;
        ms_count = 0;
        first_due = 1'b1;
        if (target == 0) begin
            res = end_move();
            return 1;
        end
        res = motion(-1, 1'b0);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_motion got, want;
        bit any;
        any = 1'b0;
        if (i_rst_n && o_valid && !i_stall) begin
            any = 1'b1;
            got = '{o_left_fwd, o_left_rev, o_right_fwd, o_right_rev, o_left_pwm,
                    o_right_pwm, o_mode, o_beep_level, o_remaining_cm, o_move_done};
            if (motion_q.size() == 0) begin
                failed = 1'b1;
                $display("%0t: unexpected word %p", $time, got);
            end else begin
                want = motion_q.pop_front();
                if (got !== want) begin
                    failed = 1'b1;
                    $display("%0t: mismatch expected %p actual %p", $time, want, got);
                end
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            any = 1'b1;
            word_cnt++;
            if (drive_step(i_action, i_side, i_direction, i_speed, i_amount, want))
                motion_q.push_back(row_typed ? row_exp : want);
        end
        idle_cycles = any ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge i_clk) begin
        if (stall_left > 0) stall_left--;
        else if (quiet) i_stall = 1'b0;
        else begin
            i_stall = ~i_stall;
            stall_left = i_stall ? gap_len() : $urandom_range(0, 6);
        end
    end

    task automatic send(t_row r);
        int seen;
        repeat (gap_len()) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_action = r.action;
        i_side = r.side;
        i_direction = r.dir;
        i_speed = r.speed;
        i_amount = r.amount;
        row_typed = r.typed;
        row_exp = r.exp;
        i_valid = 1'b1;
        seen = word_cnt;
        do @(negedge i_clk); while (word_cnt == seen);
        i_valid = 1'b0;
        row_typed = 1'b0;
    endtask

    task automatic settle();
        while (motion_q.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, longint unsigned val);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = 16'(val);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        case (idx)
            CFG_SPEED:   c_speed = val & 8'hFF;
            CFG_PERIOD:  c_period = val & 16'hFFFF;
            CFG_DIAM:    c_diam = val & 16'hFFFF;
            CFG_SLOTS:   c_slots = val & 8'hFF;
            CFG_SPACING: c_spacing = val & 16'hFFFF;
            CFG_REP_EN:  c_rep_en = val & 1;
            default:     c_beep_en = val & 1;
        endcase
    endtask

    task automatic load_cfg(int spd, int per, int diam, int slots, int spc, int ren, int ben);
        settle();
        write_reg(CFG_SPEED, spd);
        write_reg(CFG_PERIOD, per);
        write_reg(CFG_DIAM, diam);
        write_reg(CFG_SLOTS, slots);
        write_reg(CFG_SPACING, spc);
        write_reg(CFG_REP_EN, ren);
        write_reg(CFG_BEEP_EN, ben);
    endtask

    function automatic t_row mk(logic [2:0] act, logic [1:0] side, logic [1:0] dir,
                                logic [7:0] spd, logic [15:0] amt);
        t_row r;
        r = '{act, side, dir, spd, amt, 1'b0, '0};
        return r;
    endfunction

    function automatic t_row mk_exp(logic [2:0] act, logic [1:0] side, logic [1:0] dir,
                                    logic [7:0] spd, logic [15:0] amt, t_motion e);
        t_row r;
        r = '{act, side, dir, spd, amt, 1'b1, e};
        return r;
    endfunction

    function automatic t_row noise_row();
        return mk(3'($urandom), 2'($urandom), 2'($urandom), 8'($urandom), 16'($urandom));
    endfunction

    function automatic t_row random_row();
        t_row r;
        int p;
        logic [2:0] act;
        logic [15:0] amt;
        p = $urandom_range(0, 99);
        if (kind != MOVE_IDLE) begin
            if (p < 5) return noise_row();
            if (p < 15) return mk(ACT_TICK, 2'($urandom), 2'($urandom), 8'($urandom), 16'($urandom));
            return mk((p < 57) ? ACT_LEFT : ACT_RIGHT, 2'($urandom), 2'($urandom),
                      8'($urandom), 16'($urandom));
        end
        if (p < 15) return noise_row();
        if (p < 50) begin
            r = mk($urandom_range(0, 1) ? ACT_SET_DIR : ACT_SET_SPD, $urandom_range(0, 3),
                   2'($urandom), 8'($urandom), 16'($urandom));
            return r;
        end
        act = 3'($urandom_range(ACT_FWD, ACT_TURN));
        p = $urandom_range(0, 99);
        if (p < 8) amt = (act == ACT_TURN && p < 4) ? 16'h8000 : 16'h7FFF;
        else amt = 16'($urandom_range(1, 60));
        if (act == ACT_TURN && $urandom_range(0, 1)) amt = -amt;
        if (c_diam != 0 && c_slots != 0 && move_target(act, amt) > 250) begin
            amt = (act == ACT_TURN && $signed(amt) < 0) ? 16'hFFFF : 16'd1;
            if (move_target(act, amt) > 250) return noise_row();
        end
        return mk(act, 2'($urandom), 2'($urandom), 8'($urandom), amt);
    endfunction

    initial begin
        t_row tab[$];
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_SPEED;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_action = ACT_TICK;
        i_side = SIDE_LEFT;
        i_direction = DIR_STOP;
        i_speed = '0;
        i_amount = '0;
        row_typed = 1'b0;
        row_exp = '0;
        quiet = 1'b0;
        stall_left = 0;
        failed = 1'b0;
        word_cnt = 0;
        idle_cycles = 0;
        c_speed = 0; c_period = 0; c_diam = 0; c_slots = 0;
        c_spacing = 0; c_rep_en = 0; c_beep_en = 0;
        l_dir = 0; r_dir = 0; l_duty = 0; r_duty = 0;
        l_cnt = 0; r_cnt = 0; target = 0;
        kind = MOVE_IDLE; cm = 0; ms_count = 0; first_due = 1'b1;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        load_cfg(100, 3, 1664, 20, 3840, 1, 1);
        tab.push_back(mk_exp(ACT_SET_DIR, SIDE_BOTH, DIR_REV, 0, 0,
                             '{0, 1, 0, 1, 0, 0, MOVE_IDLE, 0, -1, 0}));
        tab.push_back(mk_exp(ACT_SET_SPD, SIDE_BOTH, DIR_STOP, 255, 0,
                             '{0, 1, 0, 1, 255, 255, MOVE_BACK, 4, -1, 0}));
        tab.push_back(mk(ACT_SET_SPD, SIDE_LEFT, DIR_STOP, 0, 0));
        tab.push_back(mk(ACT_SET_DIR, SIDE_RIGHT, DIR_ILLEGAL, 0, 0));
        tab.push_back(mk(ACT_SET_DIR, SIDE_NONE, DIR_FWD, 0, 0));
        tab.push_back(mk(ACT_SET_SPD, SIDE_NONE, DIR_FWD, 8'hFF, 0));
        tab.push_back(mk(ACT_SET_DIR, SIDE_LEFT, DIR_FWD, 0, 0));
        tab.push_back(mk(ACT_SET_DIR, SIDE_BOTH, DIR_STOP, 0, 0));
        tab.push_back(mk(ACT_FWD, SIDE_LEFT, DIR_STOP, 0, 16'd0));
        tab.push_back(mk(ACT_BACK, SIDE_LEFT, DIR_STOP, 0, 16'hFFFF));
        tab.push_back(mk(ACT_TURN, SIDE_LEFT, DIR_STOP, 0, 16'd0));
        tab.push_back(mk(ACT_TICK, SIDE_LEFT, DIR_STOP, 0, 0));
        tab.push_back(mk(ACT_LEFT, SIDE_LEFT, DIR_STOP, 0, 0));
        tab.push_back(mk_exp(ACT_TURN, SIDE_LEFT, DIR_STOP, 0, 16'd1,
                             '{0, 0, 0, 0, 100, 100, MOVE_IDLE, 0, -1, 1}));
        tab.push_back(mk(ACT_FWD, SIDE_LEFT, DIR_STOP, 0, 16'd1));
        tab.push_back(mk(ACT_TICK, SIDE_LEFT, DIR_STOP, 0, 0));
        tab.push_back(mk(ACT_SET_SPD, SIDE_BOTH, DIR_STOP, 9, 0));
        tab.push_back(mk(ACT_TURN, SIDE_LEFT, DIR_STOP, 0, 16'd5));
        tab.push_back(mk(ACT_TICK, SIDE_LEFT, DIR_STOP, 0, 0));
        tab.push_back(mk(ACT_TICK, SIDE_LEFT, DIR_STOP, 0, 0));
        tab.push_back(mk(ACT_TICK, SIDE_LEFT, DIR_STOP, 0, 0));
        tab.push_back(mk(ACT_LEFT, SIDE_LEFT, DIR_STOP, 0, 0));
        tab.push_back(mk(ACT_RIGHT, SIDE_LEFT, DIR_STOP, 0, 0));
        tab.push_back(mk(ACT_BACK, SIDE_LEFT, DIR_STOP, 0, 16'd2));
        tab.push_back(mk(ACT_TURN, SIDE_LEFT, DIR_STOP, 0, 16'h8000));
        foreach (tab[i]) send(tab[i]);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: load_cfg(255, 65535, 65535, 255, 65535, 1, 1);
                1: load_cfg(0, 0, 0, 0, 0, 0, 0);
                2: load_cfg(60, 1, 512, 8, 2048, 1, 0);
                3: load_cfg(1, 2, 1, 255, 1, 1, 1);
                4: load_cfg(128, 10, 1664, 20, 3840, 0, 1);
                default: load_cfg($urandom_range(1, 255), $urandom_range(1, 20),
                                  $urandom_range(256, 65535), $urandom_range(1, 255),
                                  $urandom_range(256, 65535), $urandom_range(0, 1),
                                  $urandom_range(0, 1));
            endcase
            quiet = (ph == 2);
            for (int n = 0; n < 300; n++) send(random_row());
            quiet = 1'b0;
        end

        settle();
        if (!failed)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
